[sv/kademlia_bucket_table_update_unit_defines.svh]
// Assertion macros for the bucket table update unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef KADEMLIA_BUCKET_TABLE_UPDATE_UNIT_DEFINES_SVH
`define KADEMLIA_BUCKET_TABLE_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define KBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/kbt_pkg.sv]
// Shared types and constants of the bucket table update unit.
// No dependencies; used by kbt_datapath, kbt_ctrl and the top level.
package kbt_pkg;

  localparam int unsigned MaxBucketSize = 16;
  localparam int unsigned BucketCount   = 128;
  localparam int unsigned FailLimit     = 20;
  localparam int unsigned PosW   = $clog2(MaxBucketSize);
  localparam int unsigned CntW   = $clog2(MaxBucketSize + 1);
  localparam int unsigned BktW   = $clog2(BucketCount);
  localparam int unsigned Slots  = BucketCount * MaxBucketSize;
  localparam int unsigned FcW    = 5;
  localparam int unsigned DefaultBucketSize = 10;
  localparam int unsigned DnsPort       = 53;
  localparam int unsigned MinVersion    = 1;
  localparam int unsigned DnsMinVersion = 5;

  // operation codes
  localparam logic [1:0] OP_HEARD  = 2'd0;
  localparam logic [1:0] OP_SEEN   = 2'd1;
  localparam logic [1:0] OP_FAILED = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SELF_HIGH = 2'd0;
  localparam logic [1:0] CFG_SELF_LOW  = 2'd1;
  localparam logic [1:0] CFG_BSIZE     = 2'd2;

  typedef enum logic [3:0] {
    ST_IGNORED, ST_LIVE_REFRESH, ST_SPARE_REFRESH, ST_PROMOTED, ST_ADD_LIVE,
    ST_ADD_SPARE, ST_ADD_EVICT, ST_UNCONF_REMOVED, ST_SWAPPED, ST_FAIL_COUNTED,
    ST_REMOVED_LIMIT, ST_SPARE_REMOVED, ST_NOT_FOUND
  } status_e;

  typedef enum logic [1:0] {
    SRC_UPD, SRC_FAIL, SRC_LIVE_RD, SRC_SPARE_RD
  } wsrc_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] node_id_high;
    logic [63:0] node_id_low;
    logic [31:0] host_address;
    logic [15:0] udp_port;
    logic [15:0] tcp_port;
    logic [7:0]  protocol_version;
    logic [31:0] udp_key;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [3:0]      status;
    logic [BktW-1:0] bucket_index;
    logic [CntW-1:0] live_count;
    logic [CntW-1:0] replacement_count;
  } out_t;

  // stored contact: only what matching and failure handling need
  typedef struct packed {
    logic [63:0]    id_high;
    logic [63:0]    id_low;
    logic [31:0]    host;
    logic [15:0]    udp;
    logic           confirmed;
    logic [FcW-1:0] fail_count;
  } entry_t;

  typedef struct packed {
    logic            accept;
    logic            lz1;
    logic            lz2;
    logic            cnt_rd;
    logic            cnt_ld;
    logic            rd_en;
    logic            rd_spare;
    logic [PosW-1:0] rd_idx;
    logic            wr_en;
    logic            wr_spare;
    logic [PosW-1:0] wr_idx;
    wsrc_e           wr_src;
    logic            hit_ld;
    logic            cmp_spare;
    logic            lc_inc;
    logic            lc_dec;
    logic            sc_inc;
    logic            sc_dec;
    logic            fin;
    status_e         status;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      op;
    logic            contact_ok;
    logic            match;
    logic            hit_conf;
    logic            fail_lim;
    logic [CntW-1:0] lc;
    logic [CntW-1:0] sc;
    logic [CntW-1:0] bs;
  } sts_t;

endpackage

[sv/kbt_datapath.sv]
// Datapath: config registers, bucket index, count store, live and spare lists.
// Depends on kbt_pkg; driven by kbt_ctrl through cmd_t.
module kbt_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kbt_pkg::in_t   in_data_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [63:0]    cfg_wdata_i,
  input  kbt_pkg::cmd_t  cmd_i,
  output kbt_pkg::sts_t  sts_o,
  output kbt_pkg::out_t  res_o
);
  import kbt_pkg::*;

  localparam int unsigned IdW = 128;
  localparam int unsigned NumGroups = IdW / 8;
  localparam int unsigned GrpW = $clog2(NumGroups);

  logic [63:0]       self_hi_q, self_lo_q;
  logic [4:0]        bsize_q;
  in_t               item_q;
  entry_t            hit_q;
  logic [IdW-1:0]    x;
  logic [GrpW-1:0]   grp_d, grp_q;
  logic [7:0]        byte_d, byte_q;
  logic [2:0]        bit_d;
  logic              ok_pre, ok_q;
  logic [BktW-1:0]   b_q;
  logic [2*CntW-1:0] cnt_mem [BucketCount];
  logic [BucketCount-1:0] cv_q;
  logic [2*CntW-1:0] cnt_rd_q;
  logic              cv_rd_q;
  logic [CntW-1:0]   lc_q, sc_q, bs;
  entry_t            live_mem  [Slots];
  entry_t            spare_mem [Slots];
  entry_t            live_rd_q, spare_rd_q, cmp_e, upd_e, fail_e, wdata;
  logic [FcW-1:0]    fc_next;
  logic              conf_op;
  out_t              res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_hi_q <= '0;
      self_lo_q <= '0;
      bsize_q   <= 5'(DefaultBucketSize);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SELF_HIGH: self_hi_q <= cfg_wdata_i;
        CFG_SELF_LOW:  self_lo_q <= cfg_wdata_i;
        CFG_BSIZE:     bsize_q   <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // effective bucket size
  always_comb begin
    if (bsize_q == '0) bs = CntW'(DefaultBucketSize);
    else if (CntW'(bsize_q) > CntW'(MaxBucketSize)) bs = CntW'(MaxBucketSize);
    else bs = CntW'(bsize_q);
  end

  // first nonzero byte of the distance, from the top
  always_comb begin
    x = {item_q.node_id_high ^ self_hi_q, item_q.node_id_low ^ self_lo_q};
    grp_d = '0;
    byte_d = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (x[IdW-1-8*g -: 8] != '0) begin
        grp_d  = GrpW'(g);
        byte_d = x[IdW-1-8*g -: 8];
      end
    end
    ok_pre = (item_q.host_address != '0) && (item_q.udp_port != '0) &&
             (item_q.protocol_version > 8'(MinVersion)) &&
             ((item_q.udp_port != 16'(DnsPort)) ||
              (item_q.protocol_version > 8'(DnsMinVersion))) &&
             (x != '0);
  end

  // leading one inside the chosen byte
  always_comb begin
    bit_d = '0;
    for (int i = 7; i >= 0; i--) begin
      if (byte_q[7-i]) bit_d = 3'(i);
    end
  end

  // item, bucket index and hit registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
      hit_q  <= '0;
    end
    if (cmd_i.lz1) begin
      grp_q  <= grp_d;
      byte_q <= byte_d;
      ok_q   <= ok_pre;
    end
    if (cmd_i.lz2) begin
      b_q <= (byte_q == '0) ? BktW'(BucketCount - 1) : {grp_q, bit_d};
    end
    if (cmd_i.hit_ld) hit_q <= cmp_e;
  end

  // per-bucket counts, valid bits stand for the reset value
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd) cnt_rd_q <= cnt_mem[b_q];
    if (cmd_i.fin)    cnt_mem[b_q] <= {lc_q, sc_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q    <= '0;
      cv_rd_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_rd) cv_rd_q <= cv_q[b_q];
      if (cmd_i.fin)    cv_q[b_q] <= 1'b1;
    end
  end

  // working counts
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_ld) begin
      lc_q <= cv_rd_q ? cnt_rd_q[2*CntW-1:CntW] : '0;
      sc_q <= cv_rd_q ? cnt_rd_q[CntW-1:0] : '0;
    end else begin
      if (cmd_i.lc_inc) lc_q <= lc_q + 1'b1;
      if (cmd_i.lc_dec) lc_q <= lc_q - 1'b1;
      if (cmd_i.sc_inc) sc_q <= sc_q + 1'b1;
      if (cmd_i.sc_dec) sc_q <= sc_q - 1'b1;
    end
  end

  // write data sources
  always_comb begin
    conf_op = (item_q.operation == OP_SEEN);
    upd_e.id_high    = item_q.node_id_high;
    upd_e.id_low     = item_q.node_id_low;
    upd_e.host       = item_q.host_address;
    upd_e.udp        = item_q.udp_port;
    upd_e.confirmed  = conf_op | hit_q.confirmed;
    upd_e.fail_count = conf_op ? '0 : hit_q.fail_count;
    fc_next = (hit_q.fail_count == '1) ? hit_q.fail_count : hit_q.fail_count + 1'b1;
    fail_e = hit_q;
    fail_e.fail_count = fc_next;
    case (cmd_i.wr_src)
      SRC_UPD:      wdata = upd_e;
      SRC_FAIL:     wdata = fail_e;
      SRC_LIVE_RD:  wdata = live_rd_q;
      SRC_SPARE_RD: wdata = spare_rd_q;
      default:      wdata = upd_e;
    endcase
  end

  // list memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en && !cmd_i.rd_spare) live_rd_q  <= live_mem[{b_q, cmd_i.rd_idx}];
    if (cmd_i.rd_en &&  cmd_i.rd_spare) spare_rd_q <= spare_mem[{b_q, cmd_i.rd_idx}];
    if (cmd_i.wr_en && !cmd_i.wr_spare) live_mem[{b_q, cmd_i.wr_idx}]  <= wdata;
    if (cmd_i.wr_en &&  cmd_i.wr_spare) spare_mem[{b_q, cmd_i.wr_idx}] <= wdata;
  end

  // contact match against the word just read
  always_comb begin
    cmp_e = cmd_i.cmp_spare ? spare_rd_q : live_rd_q;
    sts_o.match = ((cmp_e.id_high == item_q.node_id_high) &&
                   (cmp_e.id_low == item_q.node_id_low)) ||
                  ((cmp_e.host == item_q.host_address) && (cmp_e.udp == item_q.udp_port));
    sts_o.op         = item_q.operation;
    sts_o.contact_ok = ok_q;
    sts_o.hit_conf   = hit_q.confirmed;
    sts_o.fail_lim   = (fc_next >= FcW'(FailLimit));
    sts_o.lc         = lc_q;
    sts_o.sc         = sc_q;
    sts_o.bs         = bs;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q.status            <= cmd_i.status;
      res_q.bucket_index      <= b_q;
      res_q.live_count        <= lc_q;
      res_q.replacement_count <= sc_q;
    end
  end

  assign res_o = res_q;

endmodule

[sv/kbt_ctrl.sv]
// Sequencer: bucket lookup, list scans, shift-down removal and writes.
// Depends on kbt_pkg; commands kbt_datapath through cmd_t.
module kbt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  kbt_pkg::sts_t sts_i,
  output kbt_pkg::cmd_t cmd_o
);
  import kbt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LZ1, S_LZ2, S_CRD, S_CLD, S_LREAD, S_LCMP, S_SREAD, S_SCMP,
    S_DECIDE, S_RD0, S_RM_R, S_RM_W, S_WR, S_FIN
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] k_q, k_d, n_rm;
  logic [PosW-1:0] pos_q, pos_d;
  logic            fl_q, fl_d, fs_q, fs_d;
  logic            rm_pend_q, rm_pend_d, rm_spare_q, rm_spare_d;
  logic            wr_pend_q, wr_pend_d, wr_spare_q, wr_spare_d, wr_atpos_q, wr_atpos_d;
  logic            rd0;
  wsrc_e           wr_src_q, wr_src_d;
  status_e         status_q, status_d;
  logic            out_vld_q, out_vld_d;
  logic [CntW-1:0] wcnt;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    pos_d      = pos_q;
    fl_d       = fl_q;
    fs_d       = fs_q;
    rm_pend_d  = rm_pend_q;
    rm_spare_d = rm_spare_q;
    wr_pend_d  = wr_pend_q;
    wr_spare_d = wr_spare_q;
    wr_atpos_d = wr_atpos_q;
    wr_src_d   = wr_src_q;
    status_d   = status_q;
    out_vld_d  = out_vld_q;
    rd0        = 1'b0;
    cmd_o        = '0;
    cmd_o.status = status_q;
    cmd_o.wr_src = SRC_UPD;
    n_rm = rm_spare_q ? sts_i.sc : sts_i.lc;
    wcnt = wr_spare_q ? sts_i.sc : sts_i.lc;

    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          fl_d = 1'b0;
          fs_d = 1'b0;
          rm_pend_d = 1'b0;
          wr_pend_d = 1'b0;
          state_d = S_LZ1;
        end
      end
      S_LZ1: begin
        cmd_o.lz1 = 1'b1;
        state_d = S_LZ2;
      end
      S_LZ2: begin
        cmd_o.lz2 = 1'b1;
        state_d = S_CRD;
      end
      S_CRD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d = S_CLD;
      end
      // counts arrive; drop invalid contacts and the unused code
      S_CLD: begin
        cmd_o.cnt_ld = 1'b1;
        k_d = '0;
        if ((sts_i.op == OP_UNUSED) || ((sts_i.op != OP_FAILED) && !sts_i.contact_ok)) begin
          status_d = ST_IGNORED;
          state_d = S_FIN;
        end else begin
          state_d = S_LREAD;
        end
      end
      // live list scan, a read state and a compare state per entry
      S_LREAD: begin
        if (k_q < sts_i.lc) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = k_q[PosW-1:0];
          state_d = S_LCMP;
        end else begin
          k_d = '0;
          state_d = S_SREAD;
        end
      end
      S_LCMP: begin
        if (sts_i.match) begin
          cmd_o.hit_ld = 1'b1;
          pos_d = k_q[PosW-1:0];
          fl_d = 1'b1;
          state_d = S_DECIDE;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_LREAD;
        end
      end
      // spare list scan
      S_SREAD: begin
        if (k_q < sts_i.sc) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_spare = 1'b1;
          cmd_o.rd_idx   = k_q[PosW-1:0];
          state_d = S_SCMP;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_SCMP: begin
        cmd_o.cmp_spare = 1'b1;
        if (sts_i.match) begin
          cmd_o.hit_ld = 1'b1;
          pos_d = k_q[PosW-1:0];
          fs_d = 1'b1;
          state_d = S_DECIDE;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_SREAD;
        end
      end
      // pick the list operations for this item
      S_DECIDE: begin
        k_d = CntW'(pos_q);
        wr_src_d = SRC_UPD;
        wr_atpos_d = 1'b0;
        if (sts_i.op != OP_FAILED) begin
          if (fl_q) begin
            status_d = ST_LIVE_REFRESH;
            rm_pend_d = 1'b1; rm_spare_d = 1'b0;
            wr_pend_d = 1'b1; wr_spare_d = 1'b0;
          end else if (fs_q) begin
            if ((sts_i.op == OP_SEEN) && (sts_i.lc < sts_i.bs)) begin
              status_d = ST_PROMOTED;
              rm_pend_d = 1'b1; rm_spare_d = 1'b1;
              wr_pend_d = 1'b1; wr_spare_d = 1'b0;
            end else begin
              status_d = ST_SPARE_REFRESH;
              wr_pend_d = 1'b1; wr_spare_d = 1'b1; wr_atpos_d = 1'b1;
            end
          end else if (sts_i.lc < sts_i.bs) begin
            status_d = ST_ADD_LIVE;
            wr_pend_d = 1'b1; wr_spare_d = 1'b0;
          end else if (sts_i.sc >= sts_i.bs) begin
            status_d = ST_ADD_EVICT;
            k_d = '0;
            rm_pend_d = 1'b1; rm_spare_d = 1'b1;
            wr_pend_d = 1'b1; wr_spare_d = 1'b1;
          end else begin
            status_d = ST_ADD_SPARE;
            wr_pend_d = 1'b1; wr_spare_d = 1'b1;
          end
        end else if (fl_q) begin
          if (!sts_i.hit_conf) begin
            status_d = ST_UNCONF_REMOVED;
            rm_pend_d = 1'b1; rm_spare_d = 1'b0;
          end else if (sts_i.sc != '0) begin
            // oldest replacement takes the slot, then leaves the FIFO
            status_d = ST_SWAPPED;
            rd0 = 1'b1;
            k_d = '0;
            wr_pend_d = 1'b1; wr_spare_d = 1'b0; wr_atpos_d = 1'b1;
            wr_src_d = SRC_SPARE_RD;
            rm_pend_d = 1'b1; rm_spare_d = 1'b1;
          end else if (sts_i.fail_lim) begin
            status_d = ST_REMOVED_LIMIT;
            rm_pend_d = 1'b1; rm_spare_d = 1'b0;
          end else begin
            status_d = ST_FAIL_COUNTED;
            wr_pend_d = 1'b1; wr_spare_d = 1'b0; wr_atpos_d = 1'b1;
            wr_src_d = SRC_FAIL;
          end
        end else if (fs_q) begin
          status_d = ST_SPARE_REMOVED;
          rm_pend_d = 1'b1; rm_spare_d = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
        if (rd0) state_d = S_RD0;
        else if (rm_pend_d) state_d = S_RM_R;
        else if (wr_pend_d) state_d = S_WR;
        else state_d = S_FIN;
      end
      S_RD0: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_spare = 1'b1;
        cmd_o.rd_idx   = '0;
        state_d = S_WR;
      end
      // shift later entries down by one
      S_RM_R: begin
        if (({1'b0, k_q} + 1'b1) < {1'b0, n_rm}) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_spare = rm_spare_q;
          cmd_o.rd_idx   = PosW'(k_q + 1'b1);
          state_d = S_RM_W;
        end else begin
          cmd_o.lc_dec = !rm_spare_q;
          cmd_o.sc_dec = rm_spare_q;
          rm_pend_d = 1'b0;
          state_d = wr_pend_q ? S_WR : S_FIN;
        end
      end
      S_RM_W: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_spare = rm_spare_q;
        cmd_o.wr_idx   = k_q[PosW-1:0];
        cmd_o.wr_src   = rm_spare_q ? SRC_SPARE_RD : SRC_LIVE_RD;
        k_d = k_q + 1'b1;
        state_d = S_RM_R;
      end
      // write in place or append at the tail
      S_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_spare = wr_spare_q;
        cmd_o.wr_src   = wr_src_q;
        cmd_o.wr_idx   = wr_atpos_q ? pos_q : wcnt[PosW-1:0];
        cmd_o.lc_inc   = !wr_atpos_q && !wr_spare_q;
        cmd_o.sc_inc   = !wr_atpos_q && wr_spare_q;
        wr_pend_d = 1'b0;
        state_d = rm_pend_q ? S_RM_R : S_FIN;
      end
      S_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          out_vld_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      pos_q      <= '0;
      fl_q       <= 1'b0;
      fs_q       <= 1'b0;
      rm_pend_q  <= 1'b0;
      rm_spare_q <= 1'b0;
      wr_pend_q  <= 1'b0;
      wr_spare_q <= 1'b0;
      wr_atpos_q <= 1'b0;
      wr_src_q   <= SRC_UPD;
      status_q   <= ST_IGNORED;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      pos_q      <= pos_d;
      fl_q       <= fl_d;
      fs_q       <= fs_d;
      rm_pend_q  <= rm_pend_d;
      rm_spare_q <= rm_spare_d;
      wr_pend_q  <= wr_pend_d;
      wr_spare_q <= wr_spare_d;
      wr_atpos_q <= wr_atpos_d;
      wr_src_q   <= wr_src_d;
      status_q   <= status_d;
      out_vld_q  <= out_vld_d;
    end
  end

endmodule

[sv/kademlia_bucket_table_update_unit.sv]
// Top level of the Kademlia bucket table update unit.
// Depends on kbt_pkg, kbt_datapath, kbt_ctrl and the assertion macro header.
//
//   channel | handshake                   | word
//   --------+-----------------------------+---------------------------
//   in      | in_valid_i / in_ready_o     | in_data_i  (kbt_pkg::in_t)
//   out     | out_valid_o / out_ready_i   | out_data_o (kbt_pkg::out_t)
//   cfg     | cfg_we_i, cfg_idx_i         | cfg_wdata_i (64 bit)
//
// One word at a time: accept, two leading-zero steps, count read and count load,
// then a read and a compare state per entry scanned in the live and then the
// spare list plus a closing check at the end of each list, a decide state, a read
// and a write state per entry shifted on a removal plus a closing step, the write
// and the result post; single-port list memories and count store force that order.
// Reset clears the count valid bits at once; no clearing pass is needed.
// A result waiting on out_ready_i only stalls the next word in its final state, S_FIN.
`include "kademlia_bucket_table_update_unit_defines.svh"

module kademlia_bucket_table_update_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kbt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kbt_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_wdata_i
);
  import kbt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kbt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (out_data_o)
  );

  // checks
  `KBT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted twice")
  `KBT_ASSERT_NOW(a_live_range, out_valid_o, out_data_o.live_count <= CntW'(MaxBucketSize), "live count overflow")
  `KBT_ASSERT_NOW(a_spare_range, out_valid_o, out_data_o.replacement_count <= CntW'(MaxBucketSize), "spare count overflow")
  `KBT_ASSERT_NOW(a_status_range, out_valid_o, out_data_o.status <= ST_NOT_FOUND, "bad status")

endmodule

[tb/tb_kademlia_bucket_table_update_unit.sv]
// Testbench for the Kademlia bucket table update unit: directed and random contact events.
// Depends on kbt_pkg and kademlia_bucket_table_update_unit; predicts every result word itself.
module tb_kademlia_bucket_table_update_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import kbt_pkg::*;

  localparam int unsigned IdleWait = 200;
  localparam int unsigned StallMax = 30000;

  // predictor copy of one stored contact
  typedef struct {
    logic [63:0] idh, idl;
    logic [31:0] host;
    logic [15:0] udp, tcp;
    logic [7:0]  ver;
    logic [31:0] key;
    logic        conf;
    logic [4:0]  fc;
    logic [31:0] first_seen, last_seen;
  } contact_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;
  logic  cfg_we_i = 1'b0;
  logic  [1:0] cfg_idx_i = CFG_SELF_HIGH;
  logic  [63:0] cfg_wdata_i = '0;

  kademlia_bucket_table_update_unit DUT (.*);

  initial forever #10 clk_i = ~clk_i;

  // predictor state
  logic [63:0] own_hi, own_lo;
  logic [4:0]  bsize_reg;
  contact_t    live_tbl [BucketCount][MaxBucketSize];
  contact_t    spare_tbl[BucketCount][MaxBucketSize];
  int unsigned live_n [BucketCount];
  int unsigned spare_n[BucketCount];

  out_t        pending_q[$];
  int          fails = 0;
  int          accepted_in = 0, checked_out = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off = 1'b0;
  bit          burst_mode = 1'b1;
  int unsigned status_seen[16];

  // contacts that have been used, to replay for matches
  in_t         known_q[$];

  function automatic int unsigned bucket_of(logic [63:0] h, logic [63:0] l);
    logic [127:0] x;
    x = {h ^ own_hi, l ^ own_lo};
    for (int i = 0; i < 128; i++) if (x[127-i]) return i;
    return 127;
  endfunction

  function automatic int find_in(bit spare, int unsigned b, in_t w);
    int unsigned n;
    contact_t c;
    n = spare ? spare_n[b] : live_n[b];
    for (int k = 0; k < n; k++) begin
      c = spare ? spare_tbl[b][k] : live_tbl[b][k];
      if ((c.idh == w.node_id_high && c.idl == w.node_id_low) ||
          (c.host == w.host_address && c.udp == w.udp_port)) return k;
    end
    return -1;
  endfunction

  function automatic void drop_at(bit spare, int unsigned b, int unsigned p);
    if (spare) begin
      for (int k = p + 1; k < spare_n[b]; k++) spare_tbl[b][k-1] = spare_tbl[b][k];
      spare_n[b]--;
    end else begin
      for (int k = p + 1; k < live_n[b]; k++) live_tbl[b][k-1] = live_tbl[b][k];
      live_n[b]--;
    end
  endfunction

  function automatic void append(bit spare, int unsigned b, contact_t c);
    if (spare) begin
      if (spare_n[b] < MaxBucketSize) begin spare_tbl[b][spare_n[b]] = c; spare_n[b]++; end
    end else begin
      if (live_n[b] < MaxBucketSize) begin live_tbl[b][live_n[b]] = c; live_n[b]++; end
    end
  endfunction

  // compute the result word of one contact event and update the table copy
  function automatic out_t apply_event(in_t w);
    out_t r;
    int unsigned b, bs;
    int p;
    bit conf, ok, spare;
    contact_t c;
    status_e st;
    st = ST_IGNORED;
    b = bucket_of(w.node_id_high, w.node_id_low);
    bs = bsize_reg;
    if (bs == 0) bs = DefaultBucketSize;
    if (bs > MaxBucketSize) bs = MaxBucketSize;
    if (w.operation == OP_HEARD || w.operation == OP_SEEN) begin
      conf = (w.operation == OP_SEEN);
      ok = w.host_address != 0 && w.udp_port != 0 && w.protocol_version > 1 &&
           (w.udp_port != DnsPort || w.protocol_version > DnsMinVersion) &&
           !(w.node_id_high == own_hi && w.node_id_low == own_lo);
      if (ok) begin
        spare = 1'b0;
        p = find_in(1'b0, b, w);
        if (p < 0) begin spare = 1'b1; p = find_in(1'b1, b, w); end
        if (p >= 0) begin
          c = spare ? spare_tbl[b][p] : live_tbl[b][p];
          c.ver = w.protocol_version;
          if (w.udp_key != 0) c.key = w.udp_key;
          if (conf) begin c.conf = 1'b1; c.fc = '0; end
          if (c.first_seen == 0) c.first_seen = w.now;
          c.last_seen = w.now;
          c.idh = w.node_id_high; c.idl = w.node_id_low;
          c.host = w.host_address; c.udp = w.udp_port; c.tcp = w.tcp_port;
          if (!spare) begin
            drop_at(1'b0, b, p); append(1'b0, b, c); st = ST_LIVE_REFRESH;
          end else if (conf && live_n[b] < bs) begin
            drop_at(1'b1, b, p); append(1'b0, b, c); st = ST_PROMOTED;
          end else begin
            spare_tbl[b][p] = c; st = ST_SPARE_REFRESH;
          end
        end else begin
          c.idh = w.node_id_high; c.idl = w.node_id_low;
          c.host = w.host_address; c.udp = w.udp_port; c.tcp = w.tcp_port;
          c.ver = w.protocol_version; c.key = w.udp_key; c.conf = conf; c.fc = '0;
          c.first_seen = w.now; c.last_seen = w.now;
          if (live_n[b] < bs) begin
            append(1'b0, b, c); st = ST_ADD_LIVE;
          end else begin
            st = ST_ADD_SPARE;
            if (spare_n[b] >= bs) begin drop_at(1'b1, b, 0); st = ST_ADD_EVICT; end
            append(1'b1, b, c);
          end
        end
      end
    end else if (w.operation == OP_FAILED) begin
      p = find_in(1'b0, b, w);
      if (p >= 0) begin
        c = live_tbl[b][p];
        if (!c.conf) begin
          drop_at(1'b0, b, p); st = ST_UNCONF_REMOVED;
        end else begin
          if (c.fc != 5'd31) c.fc++;
          if (spare_n[b] != 0) begin
            live_tbl[b][p] = spare_tbl[b][0]; drop_at(1'b1, b, 0); st = ST_SWAPPED;
          end else if (c.fc >= FailLimit) begin
            drop_at(1'b0, b, p); st = ST_REMOVED_LIMIT;
          end else begin
            live_tbl[b][p] = c; st = ST_FAIL_COUNTED;
          end
        end
      end else begin
        p = find_in(1'b1, b, w);
        if (p >= 0) begin drop_at(1'b1, b, p); st = ST_SPARE_REMOVED; end
        else st = ST_NOT_FOUND;
      end
    end
    r.status = st;
    r.bucket_index = b[BktW-1:0];
    r.live_count = live_n[b][CntW-1:0];
    r.replacement_count = spare_n[b][CntW-1:0];
    return r;
  endfunction

  // send one word, then maybe idle between bursts
  task automatic send_word(in_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.insert(pending_q.size(), apply_event(w));
    accepted_in++;
    if (known_q.size() < 400 && w.operation != OP_FAILED) known_q.insert(known_q.size(), w);
    if (burst_mode && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end else if (!burst_mode) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic idle_out();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SELF_HIGH) own_hi = v;
    else if (idx == CFG_SELF_LOW) own_lo = v;
    else bsize_reg = v[4:0];
    @(posedge clk_i);
  endtask

  // random contact at a random bucket distance from own id, or with a fully random id
  function automatic in_t rand_contact(logic [1:0] op);
    in_t w;
    int unsigned sh;
    w.operation = op;
    sh = $urandom_range(0, 127);
    {w.node_id_high, w.node_id_low} = {own_hi, own_lo} ^
        ({64'd0, 64'd1} << sh) ^ ({$urandom, $urandom, $urandom, $urandom} >> (sh + 1));
    if ($urandom_range(0, 3) == 0) begin
      w.node_id_high = {$urandom, $urandom}; w.node_id_low = {$urandom, $urandom};
    end
    w.host_address = $urandom_range(0, 30) == 0 ? 32'd0 : {$urandom} | 32'h1;
    w.udp_port = $urandom_range(0, 30) == 0 ? 16'd0 :
                 ($urandom_range(0, 20) == 0 ? 16'(DnsPort) : 16'($urandom));
    w.tcp_port = 16'($urandom);
    w.protocol_version = $urandom_range(0, 10) == 0 ? 8'($urandom_range(0, 6)) : 8'($urandom);
    w.udp_key = $urandom_range(0, 4) == 0 ? 32'd0 : $urandom;
    w.now = $urandom;
    return w;
  endfunction

  function automatic in_t rand_word();
    in_t w;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (known_q.size() != 0 && k < 55) begin
      w = known_q[$urandom_range(0, known_q.size() - 1)];
      w.operation = k < 20 ? OP_FAILED : (k < 38 ? OP_SEEN : OP_HEARD);
      if ($urandom_range(0, 3) == 0) w.node_id_low = {$urandom, $urandom};
      w.udp_key = $urandom_range(0, 2) == 0 ? 32'd0 : $urandom;
      w.now = $urandom;
    end else begin
      w = rand_contact(k < 98 ? 2'($urandom_range(0, 2)) : OP_UNUSED);
    end
    return w;
  endfunction

  // directed corner cases
  task automatic test_directed();
    in_t w;
    w = rand_contact(OP_HEARD);
    w.node_id_high = '0; w.node_id_low = '0;
    send_word(w);                                  // own id: ignored
    w.node_id_high = '1; w.node_id_low = '1;
    w.host_address = '1; w.udp_port = '1; w.protocol_version = '1;
    w.tcp_port = '1; w.udp_key = '1; w.now = '1;
    send_word(w);                                  // bucket 0, all ones
    w.operation = OP_SEEN; send_word(w);           // refresh and confirm
    repeat (21) begin w.operation = OP_FAILED; send_word(w); end
    w = rand_contact(OP_HEARD); w.host_address = '0; send_word(w);
    w = rand_contact(OP_SEEN); w.udp_port = '0; send_word(w);
    w = rand_contact(OP_HEARD); w.protocol_version = 8'd1; send_word(w);
    w = rand_contact(OP_HEARD); w.udp_port = 16'(DnsPort); w.protocol_version = 8'd5;
    send_word(w);
    w.protocol_version = 8'd6; send_word(w);      // DNS port with new enough version
    w.operation = OP_UNUSED; send_word(w);
    w.node_id_high = '0; w.node_id_low = 64'd1; w.host_address = 32'h1;
    w.operation = OP_FAILED; send_word(w);        // not found, bucket 127
    idle_out();
  endtask

  // fill one bucket past both lists, then fail and promote
  task automatic test_bucket_fill(int unsigned n);
    in_t w;
    w = rand_contact(OP_HEARD);
    for (int i = 0; i < n; i++) begin
      w.node_id_low = {$urandom, 32'(i)};
      w.node_id_high = own_hi ^ 64'h0100_0000_0000_0000 ^ 64'(i);
      w.host_address = 32'h0A00_0000 + i; w.udp_port = 16'd4000;
      w.operation = (i % 3 == 0) ? OP_SEEN : OP_HEARD;
      send_word(w);
    end
    for (int i = 0; i < n; i++) begin
      w.node_id_high = own_hi ^ 64'h0100_0000_0000_0000 ^ 64'(i);
      w.host_address = 32'h0A00_0000 + i;
      w.operation = (i % 2) ? OP_FAILED : OP_SEEN;
      send_word(w);
    end
    idle_out();
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) send_word(rand_word());
    idle_out();
  endtask

  // receiver holds off long while words keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin repeat (300) @(posedge clk_i); hold_off = 1'b0; end
      repeat (20) send_word(rand_word());
    join
    idle_out();
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if (($time / 4000) % 3 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 2) != 0);
  end

  // result checker
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      checked_out++;
      if (pending_q.size() == 0) begin
        $error("unexpected result word %h", out_data_o);
        fails++;
      end else begin
        e = pending_q.pop_front();
        status_seen[e.status]++;
        if (out_data_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data_o.status); fails++;
        end
        if (out_data_o.bucket_index !== e.bucket_index) begin
          $error("bucket_index exp %0d got %0d", e.bucket_index, out_data_o.bucket_index);
          fails++;
        end
        if (out_data_o.live_count !== e.live_count) begin
          $error("live_count exp %0d got %0d", e.live_count, out_data_o.live_count); fails++;
        end
        if (out_data_o.replacement_count !== e.replacement_count) begin
          $error("replacement_count exp %0d got %0d", e.replacement_count,
                 out_data_o.replacement_count);
          fails++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallMax) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    own_hi = '0; own_lo = '0; bsize_reg = 5'(DefaultBucketSize);
    foreach (live_n[i]) begin live_n[i] = 0; spare_n[i] = 0; end
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bucket_fill(24);
    write_reg(CFG_SELF_HIGH, {$urandom, $urandom});
    write_reg(CFG_SELF_LOW, {$urandom, $urandom});
    write_reg(CFG_BSIZE, 64'd1);
    test_bucket_fill(6);
    test_random(150);
    write_reg(CFG_BSIZE, 64'd16);
    test_bucket_fill(34);
    burst_mode = 1'b0;
    test_random(150);
    burst_mode = 1'b1;
    write_reg(CFG_BSIZE, 64'd0);
    test_backpressure();
    write_reg(CFG_BSIZE, 64'd31);
    write_reg(CFG_SELF_HIGH, '1);
    write_reg(CFG_SELF_LOW, '1);
    test_random(150);
    write_reg(CFG_BSIZE, 64'd3);                   // shrink below stored lists
    test_random(110);
    write_reg(CFG_SELF_HIGH, '0);
    write_reg(CFG_SELF_LOW, '0);
    write_reg(CFG_BSIZE, 64'd2);
    test_random(20);
    $display("Covered %0d events and %0d results over seven register settings.",
             accepted_in, checked_out);
    $display("Status counts: add %0d evict %0d swap %0d limit %0d promote %0d",
             status_seen[ST_ADD_LIVE], status_seen[ST_ADD_EVICT], status_seen[ST_SWAPPED],
             status_seen[ST_REMOVED_LIMIT], status_seen[ST_PROMOTED]);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
